### rtl/core/kcfd_pkg.sv
// types, constants and the scan code decode table for the keypad code fifo
`timescale 1ns / 1ps
`default_nettype none

package kcfd_pkg;

   localparam int CODE_W = 8;
   localparam int KEY_W  = 5;
   localparam int FILL_W = 5;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [FILL_W-1:0] fill_type;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam key_type NO_KEY = key_type'(16);

   function automatic key_type decode_code(input code_type code);
      key_type key;
      case (code)
         8'hEE: key = key_type'(1);
         8'hED: key = key_type'(4);
         8'hEB: key = key_type'(7);
         8'hE7: key = key_type'(15);
         8'hDE: key = key_type'(2);
         8'hDD: key = key_type'(5);
         8'hDB: key = key_type'(8);
         8'hD7: key = key_type'(0);
         8'hBE: key = key_type'(3);
         8'hBD: key = key_type'(6);
         8'hBB: key = key_type'(9);
         8'hB7: key = key_type'(14);
         8'h7E: key = key_type'(10);
         8'h7D: key = key_type'(11);
         8'h7B: key = key_type'(12);
         8'h77: key = key_type'(13);
         default: key = NO_KEY;
      endcase
      return key;
   endfunction

endpackage

`default_nettype wire

### rtl/core/keypad_code_fifo_decoder.sv
// keypad scan code ring buffer with decode on read
//
//   channel   ports                                       transfer
//   request   start, busy, req_command, req_scan_code     start && !busy
//   response  rsp_valid, rsp_key_value, rsp_fill_level,   rsp_valid, one cycle
//             rsp_dropped
//
// a put: the response is registered at the transfer edge and shows in the next cycle, and busy stays low.
// a get goes through ST_GET, in which the registered read of the code memory is decoded;
// busy is high while the state is ST_GET.
// reset clears the positions, the count and the state; the memory is not cleared.
// the receiver cannot stall, so every response shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_fifo_decoder #(
   parameter int DEPTH = 20
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic               req_command,
   input  wire kcfd_pkg::code_type req_scan_code,
   output      logic               rsp_valid,
   output      kcfd_pkg::key_type  rsp_key_value,
   output      kcfd_pkg::fill_type rsp_fill_level,
   output      logic               rsp_dropped
);

   import kcfd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_GET
   } state_type;

   state_type       state_ff;
   logic [PW-1:0]   wr_pos_ff;
   logic [PW-1:0]   rd_pos_ff;
   logic [CW-1:0]   count_ff;
   code_type        rd_data_ff;
   logic            rsp_valid_ff;
   key_type         rsp_key_ff;
   fill_type        rsp_fill_ff;
   logic            rsp_dropped_ff;

   code_type        code_mem [DEPTH];

   logic            accept;
   logic            full;
   logic            mem_we;
   logic [PW-1:0]   wr_pos_in;
   logic [PW-1:0]   rd_pos_in;

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == FULL_CNT);
   assign mem_we    = accept && (req_command == CMD_PUT) && !full;
   assign wr_pos_in = (wr_pos_ff == LAST_POS) ? '0 : wr_pos_ff + 1'b1;
   assign rd_pos_in = (rd_pos_ff == LAST_POS) ? '0 : rd_pos_ff + 1'b1;

   // code memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_mem[wr_pos_ff] <= req_scan_code;
      end
      rd_data_ff <= code_mem[rd_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wr_pos_ff      <= '0;
         rd_pos_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_key_ff     <= NO_KEY;
         rsp_fill_ff    <= '0;
         rsp_dropped_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_command == CMD_PUT) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_key_ff   <= NO_KEY;
                     if (full) begin
                        rsp_dropped_ff <= 1'b1;
                        rsp_fill_ff    <= FILL_W'(count_ff);
                     end else begin
                        rsp_dropped_ff <= 1'b0;
                        wr_pos_ff      <= wr_pos_in;
                        count_ff       <= count_ff + 1'b1;
                        rsp_fill_ff    <= FILL_W'(count_ff + 1'b1);
                     end
                  end else begin
                     state_ff <= ST_GET;
                  end
               end
            end
            ST_GET: begin
               state_ff       <= ST_IDLE;
               rsp_valid_ff   <= 1'b1;
               rsp_dropped_ff <= 1'b0;
               if (count_ff == '0) begin
                  rsp_key_ff  <= NO_KEY;
                  rsp_fill_ff <= '0;
               end else begin
                  rsp_key_ff  <= decode_code(rd_data_ff);
                  rd_pos_ff   <= rd_pos_in;
                  count_ff    <= count_ff - 1'b1;
                  rsp_fill_ff <= FILL_W'(count_ff - 1'b1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_value  = rsp_key_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_dropped    = rsp_dropped_ff;

endmodule

`default_nettype wire
